// File: sv/battery_power_regime_supervisor_macros.svh
// Assertion macros used by the battery power regime supervisor checker.
`ifndef BATTERY_POWER_REGIME_SUPERVISOR_MACROS_SVH
`define BATTERY_POWER_REGIME_SUPERVISOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BPRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BPRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bprs_pkg.sv
// Package: widths, constants and coefficient table of the power regime supervisor.
`timescale 1ns / 1ps
package bprs_pkg;

  // Field widths
  localparam int ADC_CODE_W   = 12;
  localparam int ADC_BITS_DEF = 12;
  localparam int THR_W        = 7;
  localparam int MODE_W       = 2;
  localparam int CHG_W        = 15;
  localparam int MASK_W       = 9;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_ABOVE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_ABOVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_ABOVE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_CODE   = 2'd3;

  localparam logic [THR_W-1:0]      FULL_ABOVE_RST    = 7'd50;
  localparam logic [THR_W-1:0]      REDUCED_ABOVE_RST = 7'd25;
  localparam logic [THR_W-1:0]      LOW_ABOVE_RST     = 7'd10;
  localparam logic [ADC_CODE_W-1:0] CUTOFF_CODE_RST   = 12'd2110;

  // Regimes and their rail enables
  localparam logic [MODE_W-1:0] MODE_FULL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REDUCED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOW     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CRIT    = 2'd3;

  localparam logic [MASK_W-1:0] MASK_ALL  = 9'h1FF;
  localparam logic [MASK_W-1:0] MASK_LOW  = 9'h12C;
  localparam logic [MASK_W-1:0] MASK_NONE = 9'h000;

  // Arithmetic: Q24 accumulator, multiplier operand split into 9-bit digits
  localparam int FRAC      = 24;
  localparam int ACC_W     = 48;
  localparam int MUL_B_W   = 27;
  localparam int DIG_W     = 9;
  localparam int N_DIG     = MUL_B_W / DIG_W;
  localparam int DIG_CNT_W = $clog2(N_DIG);
  localparam int PROD_W    = ACC_W + MUL_B_W;
  localparam int N_HORNER  = 4;
  localparam int STEP_W    = $clog2(N_HORNER);
  localparam int PCT_W     = 31;
  localparam int PCT_SHIFT = PCT_W - CHG_W;

  // 6.6 V full scale in Q24
  localparam logic [MUL_B_W-1:0] V_SCALE_Q24 = 27'd110729626;

  localparam logic signed [ACC_W-1:0] C4_Q24      =  48'sd19642275149;
  localparam logic signed [ACC_W-1:0] C3_Q24      = -48'sd296267641035;
  localparam logic signed [ACC_W-1:0] C2_Q24      =  48'sd1671631512892;
  localparam logic signed [ACC_W-1:0] C1_Q24      = -48'sd4179069275347;
  localparam logic signed [ACC_W-1:0] C0_Q24      =  48'sd3904263509465;
  localparam logic signed [ACC_W-1:0] PCT_MAX_Q24 =  48'sd1677721600;

  // Shared multiplier control
  typedef struct packed {
    logic en;
    logic first;
  } mac_ctrl_t;

  // Coefficient added after Horner step idx (the leading one seeds the accumulator)
  function automatic logic signed [ACC_W-1:0] horner_coeff(input logic [STEP_W-1:0] idx);
    logic signed [ACC_W-1:0] c;
    case (idx)
      2'd0:    c = C3_Q24;
      2'd1:    c = C2_Q24;
      2'd2:    c = C1_Q24;
      default: c = C0_Q24;
    endcase
    return c;
  endfunction

endpackage

// File: sv/bprs_mac.sv
// Shared digit-serial multiplier: signed accumulator operand times one 9-bit digit per cycle while enabled.
`timescale 1ns / 1ps
module bprs_mac import bprs_pkg::*; (
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [ACC_W-1:0]  a_i,
  input  logic [DIG_W-1:0]         d_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [ACC_W+DIG_W:0] pp;
  logic signed [PROD_W-1:0]    p_d, p_q;

  // digits arrive most significant first
  assign pp  = a_i * $signed({1'b0, d_i});
  assign p_d = ctrl_i.first ? PROD_W'(pp) : (p_q <<< DIG_W) + PROD_W'(pp);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// File: sv/battery_power_regime_supervisor.sv
// Top level: battery power regime supervisor (ADC sample to charge, regime and rail mask).
//
// Input channel (in_valid_i / in_ready_o / adc_code_i): one battery divider sample per item.
// Output channel (out_valid_o / out_ready_i): regime, changed flag, charge in 1/256 %
// and rail enable mask for that sample, one result item per input item, in order.
// Config port (cfg_we_i / cfg_addr_i / cfg_wdata_i): thresholds and cutoff code, to be written
// only while the block is idle; the block does not enforce this. Wide data is truncated to the register.
//
// Sequence: a sample above the cutoff goes through the volts product, the volts shift, then
// four Horner steps, each a product and an add, then clamp and classify. The 48x9 shared
// multiplier runs five products (volts, then four Horner steps), three digit passes each.
// At or below the cutoff an item skips the multiplier and goes straight to clamp and classify.
// in_ready_o is high only while the sequencer sits idle.
//
// The result sits in an output register; a new item is accepted while it waits. If the
// receiver still stalls when the next result is ready, the sequencer holds it until the
// register frees up, then updates the stored regime.
// Reset: thresholds 50/25/10, cutoff 2110, stored regime critical, no result pending.
`timescale 1ns / 1ps
module battery_power_regime_supervisor import bprs_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample in
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ADC_CODE_W-1:0] adc_code_i,
  // result out
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MODE_W-1:0]     power_mode_o,
  output logic                  mode_changed_o,
  output logic [CHG_W-1:0]      charge_percent_o,
  output logic [MASK_W-1:0]     enable_mask_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // only the low ADC_BITS bits of the sample carry data
  localparam int CODE_W = (ADC_BITS < ADC_CODE_W) ? ADC_BITS : ADC_CODE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VMUL,
    S_VSHIFT,
    S_HMUL,
    S_HADD,
    S_CLAMP,
    S_OUT
  } state_e;

  // configuration registers
  logic [THR_W-1:0]      full_above_q, reduced_above_q, low_above_q;
  logic [ADC_CODE_W-1:0] cutoff_q;

  // sequencer and datapath registers
  state_e                  state_q;
  logic [DIG_CNT_W-1:0]    dig_q;
  logic [STEP_W-1:0]       step_q;
  logic [CODE_W-1:0]       code_q;
  logic [MUL_B_W-1:0]      v_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [PCT_W-1:0]        pct_q;
  logic [MODE_W-1:0]       current_mode_q;

  // output register
  logic                    out_valid_q;
  logic [MODE_W-1:0]       power_mode_q;
  logic                    mode_changed_q;
  logic [CHG_W-1:0]        charge_q;
  logic [MASK_W-1:0]       mask_q;

  // combinational helpers
  logic [CODE_W-1:0]        code_in;
  logic                     above_cutoff;
  logic                     dig_last;
  logic                     step_last;
  logic signed [ACC_W-1:0]  a_sel;
  logic [MUL_B_W-1:0]       b_sel;
  logic [DIG_W-1:0]         digit;
  mac_ctrl_t                mac_ctrl;
  logic signed [PROD_W-1:0] mac_p;
  logic signed [ACC_W-1:0]  prod_shr;
  logic [PCT_W-1:0]         pct_clamped;
  logic [MODE_W-1:0]        mode_nxt;
  logic [MASK_W-1:0]        mask_nxt;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_above_q    <= FULL_ABOVE_RST;
      reduced_above_q <= REDUCED_ABOVE_RST;
      low_above_q     <= LOW_ABOVE_RST;
      cutoff_q        <= CUTOFF_CODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FULL_ABOVE:    full_above_q    <= cfg_wdata_i[THR_W-1:0];
        CFG_REDUCED_ABOVE: reduced_above_q <= cfg_wdata_i[THR_W-1:0];
        CFG_LOW_ABOVE:     low_above_q     <= cfg_wdata_i[THR_W-1:0];
        CFG_CUTOFF_CODE:   cutoff_q        <= cfg_wdata_i[ADC_CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier operands
  // Volts pass: code * V_SCALE. Horner pass: acc * v. Digits MSB first.
  // ---------------------------------------------------------------------------
  assign code_in      = adc_code_i[CODE_W-1:0];
  assign above_cutoff = ADC_CODE_W'(code_in) > cutoff_q;
  assign dig_last     = dig_q == DIG_CNT_W'(N_DIG - 1);
  assign step_last    = step_q == STEP_W'(N_HORNER - 1);

  always_comb begin
    if (state_q == S_VMUL) begin
      a_sel = $signed(ACC_W'(code_q));
      b_sel = V_SCALE_Q24;
    end else begin
      a_sel = acc_q;
      b_sel = v_q;
    end
    digit = DIG_W'(b_sel >> (DIG_W * (N_DIG - 1 - int'(dig_q))));
    mac_ctrl.en    = (state_q == S_VMUL) || (state_q == S_HMUL);
    mac_ctrl.first = dig_q == '0;
  end

  bprs_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (a_sel),
    .d_i    (digit),
    .p_o    (mac_p)
  );

  // floor(a*v / 2^24): arithmetic shift of the exact product
  assign prod_shr = ACC_W'(mac_p >>> FRAC);

  // clamp to [0, 100%]
  always_comb begin
    if (acc_q > PCT_MAX_Q24) begin
      pct_clamped = PCT_W'(PCT_MAX_Q24);
    end else if (acc_q < 0) begin
      pct_clamped = '0;
    end else begin
      pct_clamped = PCT_W'(acc_q);
    end
  end

  // regime from strict compares against whole-percent thresholds
  always_comb begin
    if (pct_q > {full_above_q, {FRAC{1'b0}}}) begin
      mode_nxt = MODE_FULL;
      mask_nxt = MASK_ALL;
    end else if (pct_q > {reduced_above_q, {FRAC{1'b0}}}) begin
      mode_nxt = MODE_REDUCED;
      mask_nxt = MASK_ALL;
    end else if (pct_q > {low_above_q, {FRAC{1'b0}}}) begin
      mode_nxt = MODE_LOW;
      mask_nxt = MASK_LOW;
    end else begin
      mode_nxt = MODE_CRIT;
      mask_nxt = MASK_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      dig_q          <= '0;
      step_q         <= '0;
      code_q         <= '0;
      v_q            <= '0;
      acc_q          <= '0;
      pct_q          <= '0;
      current_mode_q <= MODE_CRIT;
      out_valid_q    <= 1'b0;
      power_mode_q   <= MODE_CRIT;
      mode_changed_q <= 1'b0;
      charge_q       <= '0;
      mask_q         <= MASK_NONE;
    end else begin
      // in S_OUT a taken result is replaced by the new one below
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            code_q <= code_in;
            dig_q  <= '0;
            step_q <= '0;
            if (above_cutoff) begin
              acc_q   <= C4_Q24;
              state_q <= S_VMUL;
            end else begin
              acc_q   <= '0;   // at or below cutoff: zero percent
              state_q <= S_CLAMP;
            end
          end
        end
        S_VMUL: begin
          if (dig_last) begin
            dig_q   <= '0;
            state_q <= S_VSHIFT;
          end else begin
            dig_q <= dig_q + 1'b1;
          end
        end
        S_VSHIFT: begin
          v_q     <= MUL_B_W'(mac_p >>> ADC_BITS);
          state_q <= S_HMUL;
        end
        S_HMUL: begin
          if (dig_last) begin
            dig_q   <= '0;
            state_q <= S_HADD;
          end else begin
            dig_q <= dig_q + 1'b1;
          end
        end
        S_HADD: begin
          acc_q <= prod_shr + horner_coeff(step_q);
          if (step_last) begin
            state_q <= S_CLAMP;
          end else begin
            step_q  <= step_q + 1'b1;
            state_q <= S_HMUL;
          end
        end
        S_CLAMP: begin
          pct_q   <= pct_clamped;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // wait here while the previous result is still held
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            power_mode_q   <= mode_nxt;
            mode_changed_q <= mode_nxt != current_mode_q;
            charge_q       <= pct_q[PCT_W-1:PCT_SHIFT];
            mask_q         <= mask_nxt;
            current_mode_q <= mode_nxt;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o       = state_q == S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign power_mode_o     = power_mode_q;
  assign mode_changed_o   = mode_changed_q;
  assign charge_percent_o = charge_q;
  assign enable_mask_o    = mask_q;

endmodule

// File: sv/bprs_checker.sv
// Port-level checker for the battery power regime supervisor, with its bind.
`timescale 1ns / 1ps
`include "battery_power_regime_supervisor_macros.svh"
module bprs_checker import bprs_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [MODE_W-1:0]     power_mode_o,
  input logic                  mode_changed_o,
  input logic [CHG_W-1:0]      charge_percent_o,
  input logic [MASK_W-1:0]     enable_mask_o
);

  logic                         in_acc;
  logic                         out_stall;
  logic                         mask_ok;
  logic                         chg_ok;
  logic [MASK_W-1:0]            mask_exp;
  logic [MODE_W+CHG_W+MASK_W:0] result_bits;

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign mask_ok     = enable_mask_o == mask_exp;
  assign chg_ok      = charge_percent_o <= CHG_W'(25600);
  assign result_bits = {power_mode_o, mode_changed_o, charge_percent_o, enable_mask_o};

  // rail enables per regime
  always_comb begin
    case (power_mode_o)
      MODE_LOW:  mask_exp = MASK_LOW;
      MODE_CRIT: mask_exp = MASK_NONE;
      default:   mask_exp = MASK_ALL;
    endcase
  end

  // one item at a time: accepting an item makes the block busy
  `BPRS_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_acc, !in_ready_o, "ready held after accept")

  // rail mask matches the reported regime whenever a result is valid
  `BPRS_ASSERT_NOW(a_mask, clk_i, rst_ni, out_valid_o, mask_ok, "enable mask off regime")

  // charge never exceeds 100 percent
  `BPRS_ASSERT_NOW(a_range, clk_i, rst_ni, out_valid_o, chg_ok, "charge above 100 percent")

  // stalled result holds
  `BPRS_ASSERT_NEXT(a_hold_v, clk_i, rst_ni, out_stall, out_valid_o, "result dropped")
  `BPRS_ASSERT_NEXT(a_hold_d, clk_i, rst_ni, out_stall, $stable(result_bits), "result changed")

endmodule

bind battery_power_regime_supervisor bprs_checker u_bprs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .power_mode_o     (power_mode_o),
  .mode_changed_o   (mode_changed_o),
  .charge_percent_o (charge_percent_o),
  .enable_mask_o    (enable_mask_o)
);
